// ----- sv/cau_pkg.sv -----
// ============================================================================
// cau_pkg
// Shared codes, defaults and control types for the complex arithmetic unit.
// ============================================================================
`default_nettype none

package cau_pkg;

    // default configuration
    localparam int DATA_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;

    // operation codes
    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_NEG = 3'd4;
    localparam logic [2:0] FUNC_MAG = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // how the output stage finishes an item
    localparam logic [1:0] KIND_DIRECT = 2'd0;
    localparam logic [1:0] KIND_MUL    = 2'd1;
    localparam logic [1:0] KIND_DIV    = 2'd2;
    localparam logic [1:0] KIND_MAG    = 2'd3;

    // control after the product stage
    typedef struct packed {
        logic       valid;
        logic [2:0] func;
    } cau_s1_t;

    // control through the iteration stages
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic       neg_re;
        logic       neg_im;
        logic       dz;
    } cau_ctl_t;

endpackage

`default_nettype wire

// ----- sv/complex_arithmetic_unit_core.sv -----
// ============================================================================
// complex_arithmetic_unit_core
// Pipelined complex ALU on signed fixed point: add, subtract, multiply,
// divide, negate and magnitude, with rounding, saturation and status.
// ============================================================================
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  in      | in_valid / in_stall   | func, x_re, x_im, y_re, y_im
//  out     | out_valid / out_stall | z_re, z_im, status
//
//  One item enters per cycle unless a held result stalls the pipeline;
//  2*DATA_WIDTH + FRAC_BITS + 4 register stages, set by the bit-per-stage
//  divider chain.
//  The square root runs in the first DATA_WIDTH divider stages.
//  Reset clears only the control registers, valid bits included; there is no state between items.
//  A held result stalls the whole pipeline at once; nothing is dropped.
//
`default_nettype none

module complex_arithmetic_unit_core #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire  [2:0]                   func,
    input  wire  signed [DATA_WIDTH-1:0] x_re,
    input  wire  signed [DATA_WIDTH-1:0] x_im,
    input  wire  signed [DATA_WIDTH-1:0] y_re,
    input  wire  signed [DATA_WIDTH-1:0] y_im,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic signed [DATA_WIDTH-1:0] z_re,
    output logic signed [DATA_WIDTH-1:0] z_im,
    output logic [1:0]                   status
);
    import cau_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int STEPS = 2 * DATA_WIDTH + FRAC_BITS + 1;
    localparam logic signed [W-1:0] DMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] DMIN = {1'b1, {(W-1){1'b0}}};

    logic                  en;
    cau_s1_t               s1;
    logic signed [2*W-1:0] p_a, p_b, p_c, p_d, p_e, p_f;
    logic signed [W:0]     sum_re, sum_im;

    cau_ctl_t              ctl_c  [0:STEPS];
    logic signed [2*W:0]   w_re_c [0:STEPS];
    logic signed [2*W:0]   w_im_c [0:STEPS];
    logic [2*W-1:0]        n_re_c [0:STEPS];
    logic [2*W-1:0]        n_im_c [0:STEPS];
    logic [2*W-1:0]        r_re_c [0:STEPS];
    logic [2*W-1:0]        r_im_c [0:STEPS];
    logic [W+1:0]          q_re_c [0:STEPS];
    logic [W+1:0]          q_im_c [0:STEPS];
    logic [2*W-1:0]        den_c  [0:STEPS];
    logic [2*W-1:0]        rad_c  [0:STEPS];
    logic [W+1:0]          rem_c  [0:STEPS];
    logic [W-1:0]          root_c [0:STEPS];

    // global advance: the pipeline moves unless a result is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    cau_prod #(.W(W)) u_prod (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid), .func(func),
        .x_re(x_re), .x_im(x_im), .y_re(y_re), .y_im(y_im), .s1(s1),
        .p_a(p_a), .p_b(p_b), .p_c(p_c), .p_d(p_d), .p_e(p_e), .p_f(p_f),
        .sum_re(sum_re), .sum_im(sum_im)
    );

    cau_comb #(.W(W)) u_comb (
        .clk(clk), .rst_n(rst_n), .en(en), .s1(s1),
        .p_a(p_a), .p_b(p_b), .p_c(p_c), .p_d(p_d), .p_e(p_e), .p_f(p_f),
        .sum_re(sum_re), .sum_im(sum_im), .ctl(ctl_c[0]),
        .w_re(w_re_c[0]), .w_im(w_im_c[0]), .n_re(n_re_c[0]), .n_im(n_im_c[0]),
        .den(den_c[0]), .rad(rad_c[0])
    );

    // iteration chain inputs start from zero
    assign r_re_c[0] = '0;
    assign r_im_c[0] = '0;
    assign q_re_c[0] = '0;
    assign q_im_c[0] = '0;
    assign rem_c[0]  = '0;
    assign root_c[0] = '0;

    // divider and square root chain
    generate
        for (genvar k = 0; k < STEPS; k++)
        begin : g_step
            cau_iter_stage #(.W(W), .IDX(k)) u_step (
                .clk(clk), .rst_n(rst_n), .en(en),
                .ctl_in(ctl_c[k]), .w_re_in(w_re_c[k]), .w_im_in(w_im_c[k]),
                .n_re_in(n_re_c[k]), .n_im_in(n_im_c[k]),
                .r_re_in(r_re_c[k]), .r_im_in(r_im_c[k]),
                .q_re_in(q_re_c[k]), .q_im_in(q_im_c[k]),
                .den_in(den_c[k]), .rad_in(rad_c[k]),
                .rem_in(rem_c[k]), .root_in(root_c[k]),
                .ctl_out(ctl_c[k+1]), .w_re_out(w_re_c[k+1]), .w_im_out(w_im_c[k+1]),
                .n_re_out(n_re_c[k+1]), .n_im_out(n_im_c[k+1]),
                .r_re_out(r_re_c[k+1]), .r_im_out(r_im_c[k+1]),
                .q_re_out(q_re_c[k+1]), .q_im_out(q_im_c[k+1]),
                .den_out(den_c[k+1]), .rad_out(rad_c[k+1]),
                .rem_out(rem_c[k+1]), .root_out(root_c[k+1])
            );
        end
    endgenerate

    cau_out #(.W(W), .F(FRAC_BITS)) u_out (
        .clk(clk), .rst_n(rst_n), .en(en), .ctl(ctl_c[STEPS]),
        .w_re(w_re_c[STEPS]), .w_im(w_im_c[STEPS]),
        .q_re(q_re_c[STEPS]), .q_im(q_im_c[STEPS]),
        .rem(rem_c[STEPS]), .root(root_c[STEPS]),
        .out_valid(out_valid), .z_re(z_re), .z_im(z_im), .status(status)
    );

`ifndef SYNTH
    // divide by zero always yields a zero result
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DZ |-> z_re == '0 && z_im == '0)
        else $error("divide by zero with nonzero result");

    // a saturated item has a part at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_SAT |->
            z_re == DMAX || z_re == DMIN || z_im == DMAX || z_im == DMIN)
        else $error("saturated status without clamped part");

    // no undefined status code leaves the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_DZ || status == ST_SAT)
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire

// ----- sv/cau_prod.sv -----
// ============================================================================
// cau_prod
// First stage: the six partial products and the add/subtract/negate sums.
// ============================================================================
`default_nettype none

module cau_prod #(
    parameter int W = 24
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_valid,
    input  wire  [2:0]          func,
    input  wire  signed [W-1:0] x_re,
    input  wire  signed [W-1:0] x_im,
    input  wire  signed [W-1:0] y_re,
    input  wire  signed [W-1:0] y_im,
    output cau_pkg::cau_s1_t    s1,
    output logic signed [2*W-1:0] p_a,
    output logic signed [2*W-1:0] p_b,
    output logic signed [2*W-1:0] p_c,
    output logic signed [2*W-1:0] p_d,
    output logic signed [2*W-1:0] p_e,
    output logic signed [2*W-1:0] p_f,
    output logic signed [W:0]     sum_re,
    output logic signed [W:0]     sum_im
);
    import cau_pkg::*;

    cau_s1_t               s1_reg, s1_next;
    logic signed [W-1:0]   sq_a, sq_b;
    logic signed [2*W-1:0] p_a_reg, p_b_reg, p_c_reg, p_d_reg, p_e_reg, p_f_reg;
    logic signed [W:0]     sum_re_reg, sum_re_next, sum_im_reg, sum_im_next;

    // operand select and short sums
    always_comb
    begin
        s1_next.valid = in_valid;
        s1_next.func  = func;
        sq_a = (func == FUNC_MAG) ? x_re : y_re;
        sq_b = (func == FUNC_MAG) ? x_im : y_im;
        case (func)
            FUNC_ADD:
            begin
                sum_re_next = (W+1)'(x_re) + (W+1)'(y_re);
                sum_im_next = (W+1)'(x_im) + (W+1)'(y_im);
            end
            FUNC_SUB:
            begin
                sum_re_next = (W+1)'(x_re) - (W+1)'(y_re);
                sum_im_next = (W+1)'(x_im) - (W+1)'(y_im);
            end
            FUNC_NEG:
            begin
                sum_re_next = -(W+1)'(x_re);
                sum_im_next = -(W+1)'(x_im);
            end
            default:
            begin
                sum_re_next = '0;
                sum_im_next = '0;
            end
        endcase
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg <= '0;
        else if (en)
            s1_reg <= s1_next;
    end

    // product registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_a_reg    <= (2*W)'(x_re) * (2*W)'(y_re);
            p_b_reg    <= (2*W)'(x_im) * (2*W)'(y_im);
            p_c_reg    <= (2*W)'(x_re) * (2*W)'(y_im);
            p_d_reg    <= (2*W)'(x_im) * (2*W)'(y_re);
            p_e_reg    <= (2*W)'(sq_a) * (2*W)'(sq_a);
            p_f_reg    <= (2*W)'(sq_b) * (2*W)'(sq_b);
            sum_re_reg <= sum_re_next;
            sum_im_reg <= sum_im_next;
        end
    end

    assign s1     = s1_reg;
    assign p_a    = p_a_reg;
    assign p_b    = p_b_reg;
    assign p_c    = p_c_reg;
    assign p_d    = p_d_reg;
    assign p_e    = p_e_reg;
    assign p_f    = p_f_reg;
    assign sum_re = sum_re_reg;
    assign sum_im = sum_im_reg;

endmodule

`default_nettype wire

// ----- sv/cau_comb.sv -----
// ============================================================================
// cau_comb
// Second stage: combines products into results, dividends, divisor and
// the magnitude radicand.
// ============================================================================
`default_nettype none

module cau_comb #(
    parameter int W = 24
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  cau_pkg::cau_s1_t      s1,
    input  wire  signed [2*W-1:0] p_a,
    input  wire  signed [2*W-1:0] p_b,
    input  wire  signed [2*W-1:0] p_c,
    input  wire  signed [2*W-1:0] p_d,
    input  wire  signed [2*W-1:0] p_e,
    input  wire  signed [2*W-1:0] p_f,
    input  wire  signed [W:0]     sum_re,
    input  wire  signed [W:0]     sum_im,
    output cau_pkg::cau_ctl_t     ctl,
    output logic signed [2*W:0]   w_re,
    output logic signed [2*W:0]   w_im,
    output logic [2*W-1:0]        n_re,
    output logic [2*W-1:0]        n_im,
    output logic [2*W-1:0]        den,
    output logic [2*W-1:0]        rad
);
    import cau_pkg::*;

    function automatic logic [2*W:0] mag_of(input logic signed [2*W:0] v);
        mag_of = v[2*W] ? -v : v;
    endfunction

    cau_ctl_t             ctl_reg, ctl_next;
    logic signed [2*W:0]  w_re_reg, w_re_next, w_im_reg, w_im_next;
    logic signed [2*W:0]  nr, ni, sq_sum;
    logic [2*W:0]         nr_mag, ni_mag;
    logic [2*W-1:0]       n_re_reg, n_im_reg, den_reg, rad_reg;

    // sums of products
    always_comb
    begin
        nr     = (2*W+1)'(p_a) + (2*W+1)'(p_b);
        ni     = (2*W+1)'(p_d) - (2*W+1)'(p_c);
        sq_sum = (2*W+1)'(p_e) + (2*W+1)'(p_f);
        nr_mag = mag_of(nr);
        ni_mag = mag_of(ni);

        ctl_next.valid  = s1.valid;
        ctl_next.neg_re = nr[2*W];
        ctl_next.neg_im = ni[2*W];
        ctl_next.dz     = (sq_sum == '0);
        w_re_next       = '0;
        w_im_next       = '0;
        case (s1.func)
            FUNC_ADD, FUNC_SUB, FUNC_NEG:
            begin
                ctl_next.kind = KIND_DIRECT;
                w_re_next     = (2*W+1)'(sum_re);
                w_im_next     = (2*W+1)'(sum_im);
            end
            FUNC_MUL:
            begin
                ctl_next.kind = KIND_MUL;
                w_re_next     = (2*W+1)'(p_a) - (2*W+1)'(p_b);
                w_im_next     = (2*W+1)'(p_c) + (2*W+1)'(p_d);
            end
            FUNC_DIV: ctl_next.kind = KIND_DIV;
            FUNC_MAG: ctl_next.kind = KIND_MAG;
            default:  ctl_next.kind = KIND_DIRECT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_re_reg <= w_re_next;
            w_im_reg <= w_im_next;
            n_re_reg <= nr_mag[2*W-1:0];
            n_im_reg <= ni_mag[2*W-1:0];
            den_reg  <= sq_sum[2*W-1:0];
            rad_reg  <= sq_sum[2*W-1:0];
        end
    end

    assign ctl  = ctl_reg;
    assign w_re = w_re_reg;
    assign w_im = w_im_reg;
    assign n_re = n_re_reg;
    assign n_im = n_im_reg;
    assign den  = den_reg;
    assign rad  = rad_reg;

endmodule

`default_nettype wire

// ----- sv/cau_iter_stage.sv -----
// ============================================================================
// cau_iter_stage
// One pipeline step: a quotient bit for both divides and, in the first
// W steps, two radicand bits of the square root.
// ============================================================================
`default_nettype none

module cau_iter_stage #(
    parameter int W   = 24,
    parameter int IDX = 0
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  cau_pkg::cau_ctl_t     ctl_in,
    input  wire  signed [2*W:0]   w_re_in,
    input  wire  signed [2*W:0]   w_im_in,
    input  wire  [2*W-1:0]        n_re_in,
    input  wire  [2*W-1:0]        n_im_in,
    input  wire  [2*W-1:0]        r_re_in,
    input  wire  [2*W-1:0]        r_im_in,
    input  wire  [W+1:0]          q_re_in,
    input  wire  [W+1:0]          q_im_in,
    input  wire  [2*W-1:0]        den_in,
    input  wire  [2*W-1:0]        rad_in,
    input  wire  [W+1:0]          rem_in,
    input  wire  [W-1:0]          root_in,
    output cau_pkg::cau_ctl_t     ctl_out,
    output logic signed [2*W:0]   w_re_out,
    output logic signed [2*W:0]   w_im_out,
    output logic [2*W-1:0]        n_re_out,
    output logic [2*W-1:0]        n_im_out,
    output logic [2*W-1:0]        r_re_out,
    output logic [2*W-1:0]        r_im_out,
    output logic [W+1:0]          q_re_out,
    output logic [W+1:0]          q_im_out,
    output logic [2*W-1:0]        den_out,
    output logic [2*W-1:0]        rad_out,
    output logic [W+1:0]          rem_out,
    output logic [W-1:0]          root_out
);
    import cau_pkg::*;

    // quotient clamp keeps overflowed quotients far above the range
    localparam logic [W+2:0] CAP = (W+3)'(1) << (W+1);

    cau_ctl_t            ctl_reg;
    logic signed [2*W:0] w_re_reg, w_im_reg;
    logic [2*W-1:0]      n_re_reg, n_im_reg, r_re_reg, r_im_reg, den_reg, rad_reg;
    logic [2*W-1:0]      r_re_next, r_im_next, rad_next;
    logic [W+1:0]        q_re_reg, q_im_reg, q_re_next, q_im_next, rem_reg, rem_next;
    logic [W-1:0]        root_reg, root_next;
    logic [2*W:0]        rs_re, rs_im, df_re, df_im;
    logic [W+2:0]        t_re, t_im;
    logic                ge_re, ge_im;

    // restoring divide step, shared divisor
    always_comb
    begin
        rs_re = {r_re_in, n_re_in[2*W-1]};
        rs_im = {r_im_in, n_im_in[2*W-1]};
        df_re = rs_re - {1'b0, den_in};
        df_im = rs_im - {1'b0, den_in};
        ge_re = (rs_re >= {1'b0, den_in});
        ge_im = (rs_im >= {1'b0, den_in});
        r_re_next = ge_re ? df_re[2*W-1:0] : rs_re[2*W-1:0];
        r_im_next = ge_im ? df_im[2*W-1:0] : rs_im[2*W-1:0];
        t_re = {q_re_in, ge_re};
        t_im = {q_im_in, ge_im};
        q_re_next = (t_re > CAP) ? CAP[W+1:0] : t_re[W+1:0];
        q_im_next = (t_im > CAP) ? CAP[W+1:0] : t_im[W+1:0];
    end

    // square root step, only in the first W stages
    generate
        if (IDX < W)
        begin : g_sqrt
            logic [W+3:0] sq_rs, sq_trial, sq_df;
            logic         sq_ge;
            always_comb
            begin
                sq_rs     = {rem_in, rad_in[2*W-1 -: 2]};
                sq_trial  = {2'b00, root_in, 2'b01};
                sq_df     = sq_rs - sq_trial;
                sq_ge     = (sq_rs >= sq_trial);
                rem_next  = sq_ge ? sq_df[W+1:0] : sq_rs[W+1:0];
                root_next = {root_in[W-2:0], sq_ge};
                rad_next  = rad_in << 2;
            end
        end
        else
        begin : g_pass
            always_comb
            begin
                rem_next  = rem_in;
                root_next = root_in;
                rad_next  = rad_in;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_re_reg <= w_re_in;
            w_im_reg <= w_im_in;
            n_re_reg <= n_re_in << 1;
            n_im_reg <= n_im_in << 1;
            r_re_reg <= r_re_next;
            r_im_reg <= r_im_next;
            q_re_reg <= q_re_next;
            q_im_reg <= q_im_next;
            den_reg  <= den_in;
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign w_re_out = w_re_reg;
    assign w_im_out = w_im_reg;
    assign n_re_out = n_re_reg;
    assign n_im_out = n_im_reg;
    assign r_re_out = r_re_reg;
    assign r_im_out = r_im_reg;
    assign q_re_out = q_re_reg;
    assign q_im_out = q_im_reg;
    assign den_out  = den_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

`default_nettype wire

// ----- sv/cau_out.sv -----
// ============================================================================
// cau_out
// Last stage: rounding, saturation, status and the output register.
// ============================================================================
`default_nettype none

module cau_out #(
    parameter int W = 24,
    parameter int F = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  cau_pkg::cau_ctl_t     ctl,
    input  wire  signed [2*W:0]   w_re,
    input  wire  signed [2*W:0]   w_im,
    input  wire  [W+1:0]          q_re,
    input  wire  [W+1:0]          q_im,
    input  wire  [W+1:0]          rem,
    input  wire  [W-1:0]          root,
    output logic                  out_valid,
    output logic signed [W-1:0]   z_re,
    output logic signed [W-1:0]   z_im,
    output logic [1:0]            status
);
    import cau_pkg::*;

    localparam logic [2*W+1:0] HALF =
        (F > 0) ? ((2*W+2)'(1) << (F > 0 ? F - 1 : 0)) : '0;
    localparam logic [2*W:0] LIM_POS = ((2*W+1)'(1) << (W - 1)) - (2*W+1)'(1);
    localparam logic [2*W:0] LIM_NEG = (2*W+1)'(1) << (W - 1);
    localparam logic [W-1:0] DMAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] DMIN    = {1'b1, {(W-1){1'b0}}};

    function automatic logic [2*W:0] mag_of(input logic signed [2*W:0] v);
        mag_of = v[2*W] ? -v : v;
    endfunction

    // apply sign and clamp; returns {saturated, value}
    function automatic logic [W:0] fix_sign(input logic [2*W:0] m, input logic neg);
        logic [W-1:0] low;
        low = m[W-1:0];
        if (neg)
            fix_sign = (m > LIM_NEG) ? {1'b1, DMIN} : {1'b0, -low};
        else
            fix_sign = (m > LIM_POS) ? {1'b1, DMAX} : {1'b0, low};
    endfunction

    logic                valid_reg;
    logic signed [W-1:0] z_re_reg, z_im_reg;
    logic [1:0]          status_reg, status_next;
    logic [W:0]          f_re, f_im;
    logic [2*W+1:0]      rnd_re, rnd_im;
    logic [W+2:0]        dq_re, dq_im;
    logic [W:0]          sq;

    always_comb
    begin
        rnd_re = ({1'b0, mag_of(w_re)} + HALF) >> F;
        rnd_im = ({1'b0, mag_of(w_im)} + HALF) >> F;
        dq_re  = ({1'b0, q_re} + (W+3)'(1)) >> 1;
        dq_im  = ({1'b0, q_im} + (W+3)'(1)) >> 1;
        sq     = (W+1)'(root) + (W+1)'(rem > (W+2)'(root));
        case (ctl.kind)
            KIND_DIRECT:
            begin
                f_re = fix_sign(mag_of(w_re), w_re[2*W]);
                f_im = fix_sign(mag_of(w_im), w_im[2*W]);
            end
            KIND_MUL:
            begin
                f_re = fix_sign(rnd_re[2*W:0], w_re[2*W]);
                f_im = fix_sign(rnd_im[2*W:0], w_im[2*W]);
            end
            KIND_DIV:
            begin
                if (ctl.dz)
                begin
                    f_re = '0;
                    f_im = '0;
                end
                else
                begin
                    f_re = fix_sign((2*W+1)'(dq_re), ctl.neg_re);
                    f_im = fix_sign((2*W+1)'(dq_im), ctl.neg_im);
                end
            end
            KIND_MAG:
            begin
                f_re = fix_sign((2*W+1)'(sq), 1'b0);
                f_im = '0;
            end
            default:
            begin
                f_re = '0;
                f_im = '0;
            end
        endcase
        if (ctl.kind == KIND_DIV && ctl.dz)
            status_next = ST_DZ;
        else if (f_re[W] || f_im[W])
            status_next = ST_SAT;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_re_reg   <= f_re[W-1:0];
            z_im_reg   <= f_im[W-1:0];
            status_reg <= status_next;
        end
    end

    assign out_valid = valid_reg;
    assign z_re      = z_re_reg;
    assign z_im      = z_im_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ============================================================================
// testbench
// Checks complex_arithmetic_unit_core against a behavioral predictor of the
// complex ALU. Directed corner items, then random items, with random stalls
// on both channels and a drain pause partway through.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import cau_pkg::*;

    localparam int DW = 24;
    localparam int FB = 16;
    localparam int LATENCY = 2 * DW + FB + 4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1130;
    localparam int QUIET_FROM = 1000;
    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic [2:0]           func;
        logic signed [DW-1:0] xr;
        logic signed [DW-1:0] xi;
        logic signed [DW-1:0] yr;
        logic signed [DW-1:0] yi;
    } op_item_t;

    typedef struct packed {
        logic signed [DW-1:0] zr;
        logic signed [DW-1:0] zi;
        logic [1:0]           st;
    } alu_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] func = '0;
    logic signed [DW-1:0] x_re = '0, x_im = '0, y_re = '0, y_im = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DW-1:0] z_re, z_im;
    logic [1:0] status;

    op_item_t    pending_items[$];
    alu_result_t expected_results[$];
    int  errors = 0;
    int  sent = 0;
    bit  stim_done = 1'b0;
    bit  hold_for_drain = 1'b0;
    int  in_gap = 0, out_gap = 0;
    int  idle_cycles = 0;

    always #2 clk = ~clk;

    complex_arithmetic_unit_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .x_re(x_re), .x_im(x_im), .y_re(y_re), .y_im(y_im),
        .out_valid(out_valid), .out_stall(out_stall),
        .z_re(z_re), .z_im(z_im), .status(status)
    );

    // ---------------- predictor ----------------
    function automatic longint round_shift(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (FB - 1))) >>> FB;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint fix_quotient(longint n, longint d);
        longint cap, q, r;
        cap = 64'sd1 <<< (DW + 1);
        q = n / d;
        r = n % d;
        if (q > cap) q = cap;
        for (int i = 0; i <= FB; i++)
        begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 1;
            end
            if (q > cap) q = cap;
        end
        return (q + 1) >>> 1;
    endfunction

    function automatic longint root_rounded(longint s);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r | (64'sd1 <<< b)) * (r | (64'sd1 <<< b)) <= s)
                r = r | (64'sd1 <<< b);
        if (s - r * r > r) r++;
        return r;
    endfunction

    function automatic longint saturate(longint v, ref bit sat);
        if (v > longint'(VMAX)) begin sat = 1'b1; return VMAX; end
        if (v < longint'(VMIN)) begin sat = 1'b1; return VMIN; end
        return v;
    endfunction

    function automatic alu_result_t compute_complex(op_item_t it);
        longint xr, xi, yr, yi, zr, zi, den, nr, ni, qr, qi;
        logic [1:0] st;
        bit sat;
        alu_result_t res;
        xr = it.xr; xi = it.xi; yr = it.yr; yi = it.yi;
        zr = 0; zi = 0; st = ST_OK; sat = 1'b0;
        case (it.func)
            FUNC_ADD: begin zr = xr + yr; zi = xi + yi; end
            FUNC_SUB: begin zr = xr - yr; zi = xi - yi; end
            FUNC_MUL:
            begin
                zr = round_shift(xr * yr - xi * yi);
                zi = round_shift(xr * yi + xi * yr);
            end
            FUNC_DIV:
            begin
                den = yr * yr + yi * yi;
                if (den == 0) st = ST_DZ;
                else
                begin
                    nr = xr * yr + xi * yi;
                    ni = xi * yr - xr * yi;
                    qr = fix_quotient(nr < 0 ? -nr : nr, den);
                    qi = fix_quotient(ni < 0 ? -ni : ni, den);
                    zr = nr < 0 ? -qr : qr;
                    zi = ni < 0 ? -qi : qi;
                end
            end
            FUNC_NEG: begin zr = -xr; zi = -xi; end
            FUNC_MAG: zr = root_rounded(xr * xr + xi * xi);
            default: ;
        endcase
        zr = saturate(zr, sat);
        zi = saturate(zi, sat);
        if (sat && st == ST_OK) st = ST_SAT;
        res.zr = zr[DW-1:0];
        res.zi = zi[DW-1:0];
        res.st = st;
        return res;
    endfunction

    // ---------------- reporting ----------------
    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endtask

    // ---------------- driver ----------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(compute_complex({func, x_re, x_im, y_re, y_im}));
                sent++;
            end
            if (in_valid && in_stall)
                ;
            else if (in_gap > 0 || hold_for_drain || pending_items.size() == 0)
            begin
                in_valid <= 1'b0;
                if (in_gap > 0) in_gap--;
            end
            else if (sent < QUIET_FROM && $urandom_range(0, 9) == 0)
            begin
                in_valid <= 1'b0;
                in_gap = $urandom_range(1, 6) - 1;
            end
            else
            begin
                op_item_t it;
                it = pending_items.pop_front();
                in_valid <= 1'b1;
                func <= it.func;
                x_re <= it.xr; x_im <= it.xi; y_re <= it.yr; y_im <= it.yi;
            end
        end
    end

    // ---------------- monitor and out-side stalls ----------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall || out_valid && !out_stall) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", z_re, 0);
                else
                begin
                    alu_result_t e;
                    e = expected_results.pop_front();
                    if (z_re !== e.zr) report_mismatch("z_re", z_re, e.zr);
                    if (z_im !== e.zi) report_mismatch("z_im", z_im, e.zi);
                    if (status !== e.st) report_mismatch("status", status, e.st);
                end
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end
            else if (sent < QUIET_FROM && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                out_gap <= $urandom_range(1, 6) - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return VMAX;
            1: return VMIN;
            2: return '0;
            3: return DW'($signed(DW'($urandom_range(0, 1 << 18))) - (1 << 17));
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic add_item(logic [2:0] f, logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                            logic signed [DW-1:0] c, logic signed [DW-1:0] d);
        pending_items.push_back({f, a, b, c, d});
    endtask

    initial
    begin
        logic [2:0] f;
        // directed corners
        add_item(FUNC_ADD, VMAX, VMAX, VMAX, 24'sd1);
        add_item(FUNC_ADD, VMIN, VMIN, -24'sd1, VMIN);
        add_item(FUNC_SUB, VMIN, VMAX, 24'sd1, VMIN);
        add_item(FUNC_SUB, 24'sd65536, -24'sd5, 24'sd3, 24'sd7);
        add_item(FUNC_MUL, VMAX, VMAX, VMAX, VMAX);
        add_item(FUNC_MUL, VMIN, VMIN, VMIN, VMIN);
        add_item(FUNC_MUL, 24'sd65536, 24'sd32768, -24'sd65536, 24'sd1);
        add_item(FUNC_MUL, 24'sd1, 24'sd0, 24'sd32768, 24'sd0);
        add_item(FUNC_DIV, 24'sd65536, 24'sd65536, 24'sd0, 24'sd0);
        add_item(FUNC_DIV, VMAX, VMIN, 24'sd0, 24'sd0);
        add_item(FUNC_DIV, VMAX, VMAX, 24'sd1, 24'sd0);
        add_item(FUNC_DIV, VMIN, VMIN, VMIN, VMAX);
        add_item(FUNC_DIV, 24'sd65536, 24'sd0, 24'sd0, -24'sd196608);
        add_item(FUNC_NEG, VMIN, VMIN, 24'sd0, 24'sd0);
        add_item(FUNC_NEG, VMAX, -24'sd1, VMAX, VMIN);
        add_item(FUNC_MAG, VMIN, VMIN, 24'sd0, 24'sd0);
        add_item(FUNC_MAG, VMAX, 24'sd0, 24'sd0, 24'sd0);
        add_item(FUNC_MAG, 24'sd196608, -24'sd262144, 24'sd0, 24'sd0);
        add_item(FUNC_MAG, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
        add_item(3'd6, VMAX, VMIN, VMAX, VMIN);
        add_item(3'd7, -24'sd1, -24'sd1, -24'sd1, -24'sd1);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            if (f == FUNC_DIV && $urandom_range(0, 9) == 0)
                add_item(f, pick_value(), pick_value(), '0, '0);
            else
                add_item(f, pick_value(), pick_value(), pick_value(), pick_value());
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // drain pause partway through
        wait (sent >= 400);
        @(posedge clk);
        hold_for_drain <= 1'b1;
        wait (expected_results.size() == 0);
        @(posedge clk);
        hold_for_drain <= 1'b0;

        wait (pending_items.size() == 0 && !(in_valid && in_stall));
        @(posedge clk);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        stim_done = 1'b1;
    end

    // ---------------- end of run ----------------
    initial
    begin
        wait (stim_done || idle_cycles >= WATCHDOG_LIMIT);
        if (!stim_done)
            $display("complex_arithmetic_unit_core test failed");
        else if (errors == 0 && expected_results.size() == 0)
            $display("complex_arithmetic_unit_core test passed");
        else
            $display("complex_arithmetic_unit_core test failed");
        $finish;
    end
endmodule

// ----- files.f -----
sv/cau_pkg.sv
sv/cau_prod.sv
sv/cau_comb.sv
sv/cau_iter_stage.sv
sv/cau_out.sv
sv/complex_arithmetic_unit_core.sv
test/testbench.sv
